// ----- rtl/spr_pkg.sv -----
`default_nettype none

package spr_pkg;

   localparam int MAX_ITERATIONS = 16;
   localparam int PIXEL_BITS     = 16;
   localparam int ITER_W         = 5;
   localparam int COORD_W        = 14;
   localparam int RES_W          = 32;
   localparam int OUT_FRAC_W     = 16;
   localparam int FRAC_W         = 32;
   // Each iteration adds two fractional bits to every pixel value.
   localparam int VAL_W          = PIXEL_BITS + 2 * MAX_ITERATIONS;
   // The offset sum stays below 2^FRAC_W in magnitude.
   localparam int OFF_W          = FRAC_W + 1;
   localparam int SHIFT_W        = $clog2(FRAC_W + 1);

   typedef logic [VAL_W-1:0] val_type;
   typedef logic signed [OFF_W-1:0] off_type;

   typedef enum logic [1:0] {
      QUAD_UL,
      QUAD_UR,
      QUAD_DR,
      QUAD_DL
   } quad_type;

   typedef struct packed {
      val_type                ul;
      val_type                u;
      val_type                ur;
      val_type                l;
      val_type                c;
      val_type                r;
      val_type                dl;
      val_type                d;
      val_type                dr;
      off_type                off_x;
      off_type                off_y;
      logic [COORD_W-1:0]     sx;
      logic [COORD_W-1:0]     sy;
   } win_type;

   typedef struct packed {
      win_type  w;
      val_type  q_ul;
      val_type  q_ur;
      val_type  q_dr;
      val_type  q_dl;
      quad_type quad;
   } quad_stage_type;

   // Weighted sum of a neighbor pair and a doubled pixel.
   function automatic val_type mix3(val_type a, val_type b, val_type twice);
      return a + b + {twice[VAL_W-2:0], 1'b0};
   endfunction

   // Diagonal step of one iteration in units of 2^-FRAC_W pixel.
   function automatic off_type step_of(logic [ITER_W-1:0] idx);
      logic [SHIFT_W-1:0] sh;
      sh = SHIFT_W'(FRAC_W - 1) - SHIFT_W'(idx);
      return off_type'(OFF_W'(1) << sh);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/spr_req_if.sv -----
`default_nettype none

interface spr_req_if;
   logic                               valid;
   logic                               ready;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_up_left;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_up;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_up_right;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_left;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_center;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_right;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_down_left;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_down;
   logic [spr_pkg::PIXEL_BITS-1:0]     p_down_right;
   logic [spr_pkg::COORD_W-1:0]        start_x;
   logic [spr_pkg::COORD_W-1:0]        start_y;

   modport source (
      output valid, p_up_left, p_up, p_up_right, p_left, p_center, p_right,
             p_down_left, p_down, p_down_right, start_x, start_y,
      input  ready
   );

   modport sink (
      input  valid, p_up_left, p_up, p_up_right, p_left, p_center, p_right,
             p_down_left, p_down, p_down_right, start_x, start_y,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/spr_rsp_if.sv -----
`default_nettype none

interface spr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [spr_pkg::RES_W-1:0]  refined_x;
   logic signed [spr_pkg::RES_W-1:0]  refined_y;

   modport source (
      output valid, refined_x, refined_y,
      input  ready
   );

   modport sink (
      input  valid, refined_x, refined_y,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/spr_quad.sv -----
`default_nettype none

// First half of one iteration: quadrant sums and the winning quadrant.
module spr_quad (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire spr_pkg::win_type        in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output spr_pkg::quad_stage_type      out_data
);

   logic                     valid_ff;
   logic                     valid_in;
   spr_pkg::quad_stage_type  data_ff;
   spr_pkg::quad_stage_type  data_in;
   logic                     load;
   spr_pkg::val_type         best;

   always_comb begin
      data_in.w    = in_data;
      data_in.q_ul = spr_pkg::mix3(in_data.l, in_data.u, in_data.c);
      data_in.q_ur = spr_pkg::mix3(in_data.u, in_data.r, in_data.c);
      data_in.q_dr = spr_pkg::mix3(in_data.r, in_data.d, in_data.c);
      data_in.q_dl = spr_pkg::mix3(in_data.d, in_data.l, in_data.c);
      // Strictly greater keeps the earlier quadrant on a tie.
      best         = data_in.q_ul;
      data_in.quad = spr_pkg::QUAD_UL;
      if (data_in.q_ur > best) begin
         best         = data_in.q_ur;
         data_in.quad = spr_pkg::QUAD_UR;
      end
      if (data_in.q_dr > best) begin
         best         = data_in.q_dr;
         data_in.quad = spr_pkg::QUAD_DR;
      end
      if (data_in.q_dl > best) begin
         data_in.quad = spr_pkg::QUAD_DL;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/spr_interp.sv -----
`default_nettype none

// Second half of one iteration: move the position and re-interpolate the
// eight neighbors around the winning quadrant; inactive slots pass it as is.
module spr_interp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [spr_pkg::ITER_W-1:0]     stage_idx,
   input  wire logic [spr_pkg::ITER_W-1:0]     iterations,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire spr_pkg::quad_stage_type        in_data,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output spr_pkg::win_type                    out_data
);

   logic              valid_ff;
   logic              valid_in;
   spr_pkg::win_type  data_ff;
   spr_pkg::win_type  data_in;
   spr_pkg::win_type  w;
   spr_pkg::win_type  nw;
   spr_pkg::off_type  step;
   spr_pkg::val_type  corner;
   logic              load;
   logic              active;

   // Stage indexes stay below MAX_ITERATIONS, so this also clamps the count.
   assign active = stage_idx < iterations;
   assign step   = spr_pkg::step_of(stage_idx);

   always_comb begin
      w      = in_data.w;
      nw     = w;
      corner = (spr_pkg::val_type'(0));
      nw.c   = in_data.q_ul;
      unique case (in_data.quad)
         spr_pkg::QUAD_UL: begin
            nw.c     = in_data.q_ul;
            corner   = spr_pkg::mix3(w.l, w.u, w.ul);
            nw.ul    = corner;
            nw.ur    = spr_pkg::mix3(w.c, w.ur, w.u);
            nw.dr    = in_data.q_dr;
            nw.dl    = spr_pkg::mix3(w.dl, w.c, w.l);
            nw.l     = spr_pkg::mix3(corner >> 2, w.c, w.l);
            nw.u     = spr_pkg::mix3(corner >> 2, w.c, w.u);
            nw.r     = in_data.q_ur;
            nw.d     = in_data.q_dl;
            nw.off_x = w.off_x - step;
            nw.off_y = w.off_y - step;
         end
         spr_pkg::QUAD_UR: begin
            nw.c     = in_data.q_ur;
            corner   = spr_pkg::mix3(w.r, w.u, w.ur);
            nw.ul    = spr_pkg::mix3(w.ul, w.c, w.u);
            nw.ur    = corner;
            nw.dr    = spr_pkg::mix3(w.dr, w.c, w.r);
            nw.dl    = in_data.q_dl;
            nw.l     = in_data.q_ul;
            nw.u     = spr_pkg::mix3(corner >> 2, w.c, w.u);
            nw.r     = spr_pkg::mix3(corner >> 2, w.c, w.r);
            nw.d     = in_data.q_dr;
            nw.off_x = w.off_x + step;
            nw.off_y = w.off_y - step;
         end
         spr_pkg::QUAD_DR: begin
            nw.c     = in_data.q_dr;
            corner   = spr_pkg::mix3(w.r, w.d, w.dr);
            nw.ul    = in_data.q_ul;
            nw.ur    = spr_pkg::mix3(w.ur, w.c, w.r);
            nw.dr    = corner;
            nw.dl    = spr_pkg::mix3(w.dl, w.c, w.d);
            nw.l     = in_data.q_dl;
            nw.u     = in_data.q_ur;
            nw.r     = spr_pkg::mix3(corner >> 2, w.c, w.r);
            nw.d     = spr_pkg::mix3(corner >> 2, w.c, w.d);
            nw.off_x = w.off_x + step;
            nw.off_y = w.off_y + step;
         end
         spr_pkg::QUAD_DL: begin
            nw.c     = in_data.q_dl;
            corner   = spr_pkg::mix3(w.l, w.d, w.dl);
            nw.ul    = spr_pkg::mix3(w.ul, w.c, w.l);
            nw.ur    = in_data.q_ur;
            nw.dr    = spr_pkg::mix3(w.c, w.dr, w.d);
            nw.dl    = corner;
            nw.l     = spr_pkg::mix3(corner >> 2, w.c, w.l);
            nw.u     = in_data.q_ul;
            nw.r     = in_data.q_dr;
            nw.d     = spr_pkg::mix3(corner >> 2, w.c, w.d);
            nw.off_x = w.off_x - step;
            nw.off_y = w.off_y + step;
         end
         default: begin
            nw = w;
         end
      endcase
      data_in = active ? nw : w;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

`ifndef SYNTHESIS
   a_center_is_max: assert property (@(posedge clock) disable iff (reset)
      load && active |=> data_ff.c >= $past(in_data.q_ul) &&
                         data_ff.c >= $past(in_data.q_ur) &&
                         data_ff.c >= $past(in_data.q_dr) &&
                         data_ff.c >= $past(in_data.q_dl))
      else $error("new center is below one of the quadrant sums");

   a_step_size: assert property (@(posedge clock) disable iff (reset)
      load && active |=>
         (data_ff.off_x - $past(in_data.w.off_x)) == $past(step) ||
         (data_ff.off_x - $past(in_data.w.off_x)) == -$past(step))
      else $error("x offset moved by other than one diagonal step");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      load && !active |=> data_ff == $past(in_data.w))
      else $error("idle iteration stage altered the item");
`endif

endmodule

`default_nettype wire

// ----- rtl/spr_out.sv -----
`default_nettype none

// Output register: start position plus floored offset in 2^-16 pixel units.
module spr_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire spr_pkg::win_type   in_data,
   spr_rsp_if.source               rsp
);

   logic                               valid_ff;
   logic                               valid_in;
   logic signed [spr_pkg::RES_W-1:0]   x_ff;
   logic signed [spr_pkg::RES_W-1:0]   x_in;
   logic signed [spr_pkg::RES_W-1:0]   y_ff;
   logic signed [spr_pkg::RES_W-1:0]   y_in;
   logic                               load;

   // The arithmetic shift floors toward minus infinity.
   assign x_in = spr_pkg::RES_W'({in_data.sx, {spr_pkg::OUT_FRAC_W{1'b0}}})
               + spr_pkg::RES_W'(in_data.off_x >>> spr_pkg::OUT_FRAC_W);
   assign y_in = spr_pkg::RES_W'({in_data.sy, {spr_pkg::OUT_FRAC_W{1'b0}}})
               + spr_pkg::RES_W'(in_data.off_y >>> spr_pkg::OUT_FRAC_W);

   assign in_ready      = !valid_ff || rsp.ready;
   assign load          = in_valid && in_ready;
   assign valid_in      = in_ready ? in_valid : valid_ff;
   assign rsp.valid     = valid_ff;
   assign rsp.refined_x = x_ff;
   assign rsp.refined_y = y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/subpixel_peak_refine_3x3.sv -----
// Sub-pixel peak refinement over a 3x3 pixel window.
// The req channel carries one item per window: nine pixels and the integer
// position of the center pixel. The rsp channel returns one item per request
// with the refined x and y in units of 1/65536 pixel, in request order.
// Both channels use valid/ready; an item moves when both are high.
// The csr port sets the iteration count (values above 16 act as 16); write
// it only while no item is in flight.
// Every item passes through 16 iteration slots of two register stages each,
// followed by the output register, whatever the iteration count. The first
// stage loads at the edge that accepts the request. A new item can enter in
// every cycle unless rsp stalls with every stage full. Slots beyond the
// iteration count pass the item unchanged.
// Each stage holds its own valid bit and is ready when empty or when the
// next stage takes its item, so bubbles close up while rsp is stalled and
// req keeps accepting until every stage is full.
// Reset clears all valid bits and sets the iteration count to 10.
`default_nettype none

module subpixel_peak_refine_3x3 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [spr_pkg::ITER_W-1:0]    csr_wdata,
   spr_req_if.sink                            req,
   spr_rsp_if.source                          rsp
);

   logic [spr_pkg::ITER_W-1:0]  iter_ff;
   logic [spr_pkg::ITER_W-1:0]  iter_in;

   // win_* link the iteration slots; q_* link the two halves of a slot.
   spr_pkg::win_type         win_data [spr_pkg::MAX_ITERATIONS+1];
   logic                     win_valid [spr_pkg::MAX_ITERATIONS+1];
   logic                     win_ready [spr_pkg::MAX_ITERATIONS+1];
   spr_pkg::quad_stage_type  q_data [spr_pkg::MAX_ITERATIONS];
   logic                     q_valid [spr_pkg::MAX_ITERATIONS];
   logic                     q_ready [spr_pkg::MAX_ITERATIONS];

   assign iter_in = csr_we ? csr_wdata : iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= spr_pkg::ITER_W'(10);
      end else begin
         iter_ff <= iter_in;
      end
   end

   // Pixels start as integers on the coarsest grid, with no offset yet.
   always_comb begin
      win_data[0].ul    = spr_pkg::VAL_W'(req.p_up_left);
      win_data[0].u     = spr_pkg::VAL_W'(req.p_up);
      win_data[0].ur    = spr_pkg::VAL_W'(req.p_up_right);
      win_data[0].l     = spr_pkg::VAL_W'(req.p_left);
      win_data[0].c     = spr_pkg::VAL_W'(req.p_center);
      win_data[0].r     = spr_pkg::VAL_W'(req.p_right);
      win_data[0].dl    = spr_pkg::VAL_W'(req.p_down_left);
      win_data[0].d     = spr_pkg::VAL_W'(req.p_down);
      win_data[0].dr    = spr_pkg::VAL_W'(req.p_down_right);
      win_data[0].off_x = '0;
      win_data[0].off_y = '0;
      win_data[0].sx    = req.start_x;
      win_data[0].sy    = req.start_y;
   end

   assign win_valid[0] = req.valid;
   assign req.ready    = win_ready[0];

   for (genvar i = 0; i < spr_pkg::MAX_ITERATIONS; i++) begin : g_iter
      spr_quad u_quad (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (win_valid[i]),
         .in_ready  (win_ready[i]),
         .in_data   (win_data[i]),
         .out_valid (q_valid[i]),
         .out_ready (q_ready[i]),
         .out_data  (q_data[i])
      );

      spr_interp u_interp (
         .clock      (clock),
         .reset      (reset),
         .stage_idx  (spr_pkg::ITER_W'(i)),
         .iterations (iter_ff),
         .in_valid   (q_valid[i]),
         .in_ready   (q_ready[i]),
         .in_data    (q_data[i]),
         .out_valid  (win_valid[i+1]),
         .out_ready  (win_ready[i+1]),
         .out_data   (win_data[i+1])
      );
   end

   spr_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (win_valid[spr_pkg::MAX_ITERATIONS]),
      .in_ready (win_ready[spr_pkg::MAX_ITERATIONS]),
      .in_data  (win_data[spr_pkg::MAX_ITERATIONS]),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// ----- verif/peak_refine_check.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register ports of the peak refiner,
// predicts the refined position of every accepted window and compares it
// with the results in arrival order.
module peak_refine_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [spr_pkg::ITER_W-1:0] csr_wdata,
   spr_req_if                         req,
   spr_rsp_if                         rsp,
   output int                         mismatches,
   output int                         outstanding
);

   typedef logic [spr_pkg::PIXEL_BITS-1:0] window_type [9];

   typedef struct {
      logic signed [spr_pkg::RES_W-1:0] x;
      logic signed [spr_pkg::RES_W-1:0] y;
   } position_type;

   logic [spr_pkg::ITER_W-1:0] iter_setting;
   position_type               expected_positions [$];

   // Window order is up-left, up, up-right, left, center, right, down-left,
   // down, down-right. Pixel values after pass i are scaled by 4^i.
   function automatic position_type refine_position(
      input window_type                  win,
      input logic [spr_pkg::COORD_W-1:0] sx,
      input logic [spr_pkg::COORD_W-1:0] sy,
      input logic [spr_pkg::ITER_W-1:0]  iters);
      logic [63:0]       ul, u, ur, l, c, r, dl, d, dr;
      logic [63:0]       q_ul, q_ur, q_dr, q_dl, best;
      logic [63:0]       nul, nu, nur, nl, nr, ndl, nd, ndr;
      longint            off_x, off_y, step;
      int                count, i;
      spr_pkg::quad_type quad;
      position_type      pos;
      ul = win[0]; u = win[1]; ur = win[2];
      l  = win[3]; c = win[4]; r  = win[5];
      dl = win[6]; d = win[7]; dr = win[8];
      count = (iters > spr_pkg::MAX_ITERATIONS) ? spr_pkg::MAX_ITERATIONS : int'(iters);
      off_x = 0;
      off_y = 0;
      for (i = 0; i < count; i++) begin
         q_ul = l + u + (c << 1);
         q_ur = u + r + (c << 1);
         q_dr = r + d + (c << 1);
         q_dl = d + l + (c << 1);
         // Strict compares keep the first quadrant in tie order.
         quad = spr_pkg::QUAD_UL;
         best = q_ul;
         if (q_ur > best) begin
            quad = spr_pkg::QUAD_UR;
            best = q_ur;
         end
         if (q_dr > best) begin
            quad = spr_pkg::QUAD_DR;
            best = q_dr;
         end
         if (q_dl > best) begin
            quad = spr_pkg::QUAD_DL;
            best = q_dl;
         end
         step = longint'(1) << (31 - i);
         case (quad)
            spr_pkg::QUAD_UL: begin
               off_x -= step; off_y -= step;
               nul = l + u + (ul << 1);
               nur = c + ur + (u << 1);
               ndr = q_dr;
               ndl = dl + c + (l << 1);
               nl  = (nul >> 2) + c + (l << 1);
               nu  = (nul >> 2) + c + (u << 1);
               nr  = q_ur;
               nd  = q_dl;
            end
            spr_pkg::QUAD_UR: begin
               off_x += step; off_y -= step;
               nul = (u << 1) + ul + c;
               nur = (ur << 1) + r + u;
               ndr = (r << 1) + dr + c;
               ndl = q_dl;
               nl  = q_ul;
               nu  = (nur >> 2) + c + (u << 1);
               nr  = (nur >> 2) + c + (r << 1);
               nd  = q_dr;
            end
            spr_pkg::QUAD_DR: begin
               off_x += step; off_y += step;
               nul = q_ul;
               nur = ur + (r << 1) + c;
               ndr = (dr << 1) + r + d;
               ndl = (d << 1) + dl + c;
               nl  = q_dl;
               nu  = q_ur;
               nr  = (ndr >> 2) + (r << 1) + c;
               nd  = (ndr >> 2) + (d << 1) + c;
            end
            default: begin
               off_x -= step; off_y += step;
               nul = (l << 1) + ul + c;
               nur = q_ur;
               ndr = c + dr + (d << 1);
               ndl = (dl << 1) + l + d;
               nl  = (ndl >> 2) + (l << 1) + c;
               nu  = q_ul;
               nr  = q_dr;
               nd  = (ndl >> 2) + (d << 1) + c;
            end
         endcase
         c  = best;
         ul = nul; u = nu; ur = nur;
         l  = nl;  r = nr;
         dl = ndl; d = nd; dr = ndr;
      end
      // The arithmetic shift floors the offset to units of 2^-16 pixel.
      pos.x = spr_pkg::RES_W'(longint'(sx) * 65536 + (off_x >>> 16));
      pos.y = spr_pkg::RES_W'(longint'(sy) * 65536 + (off_y >>> 16));
      return pos;
   endfunction

   always @(posedge clock) begin : watch
      position_type want;
      position_type fresh;
      if (reset) begin
         expected_positions.delete();
         iter_setting = 10;
         mismatches   = 0;
      end else begin
         if (csr_we)
            iter_setting = csr_wdata;
         if (req.valid && req.ready) begin
            fresh = refine_position(
               '{req.p_up_left, req.p_up, req.p_up_right,
                 req.p_left, req.p_center, req.p_right,
                 req.p_down_left, req.p_down, req.p_down_right},
               req.start_x, req.start_y, iter_setting);
            expected_positions.insert(expected_positions.size(), fresh);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_positions.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result x=%0d y=%0d with no window pending",
                           $realtime, rsp.refined_x, rsp.refined_y);
               mismatches++;
            end else begin
               want = expected_positions[0];
               expected_positions.delete(0);
               if (rsp.refined_x !== want.x || rsp.refined_y !== want.y) begin
                  if (mismatches < 10)
                     $display("%0t: expected x=%0d y=%0d, got x=%0d y=%0d",
                              $realtime, want.x, want.y,
                              rsp.refined_x, rsp.refined_y);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_positions.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// Top of the peak refiner test. It builds the clock and reset, drives the
// windows and the iteration register, and throttles the result side. The
// checker beside the block predicts and compares every result and reports
// the number of failures back here for the verdict.
module tb;

   typedef logic [spr_pkg::PIXEL_BITS-1:0] window_type [9];

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [spr_pkg::ITER_W-1:0] csr_wdata = '0;

   // While steady is set neither side inserts idle cycles, so the pipeline
   // runs full for a long stretch.
   bit                steady = 1'b0;
   int                mismatches;
   int                outstanding;

   spr_req_if req ();
   spr_rsp_if rsp ();

   always #5 clock = ~clock;

   subpixel_peak_refine_3x3 DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp       (rsp)
   );

   peak_refine_check refine_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req         (req),
      .rsp         (rsp),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // The result side stalls in about one cycle of ten, except while steady.
   always @(negedge clock) begin
      rsp.ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   // Presents one window and holds it until the block accepts it. Random idle
   // cycles are inserted first unless steady is set, each one a full clock with
   // valid low, so valid is never lowered and raised within the same time step.
   task automatic send_window(input window_type win,
                              input logic [spr_pkg::COORD_W-1:0] sx,
                              input logic [spr_pkg::COORD_W-1:0] sy);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.p_up_left    <= win[0];
      req.p_up         <= win[1];
      req.p_up_right   <= win[2];
      req.p_left       <= win[3];
      req.p_center     <= win[4];
      req.p_right      <= win[5];
      req.p_down_left  <= win[6];
      req.p_down       <= win[7];
      req.p_down_right <= win[8];
      req.start_x      <= sx;
      req.start_y      <= sy;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // The iteration count may only change with the pipeline empty, so the
   // request side goes quiet and every pending result is drained first.
   task automatic set_iterations(input logic [spr_pkg::ITER_W-1:0] count);
      req.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random window drawn from one of several shapes. Plain noise and
   // star-like peaks make up most of it; the rest are tiny-valued, flat or
   // two-level windows that force quadrant ties, and windows near full scale.
   function automatic window_type random_window();
      window_type win;
      int         shape, base, k;
      shape = $urandom_range(0, 9);
      base  = $urandom_range(0, 65535);
      for (k = 0; k < 9; k++) begin
         case (shape)
            4, 5: begin
               base   = (base < 1024) ? base + 1024 : base;
               win[k] = spr_pkg::PIXEL_BITS'(base - $urandom_range(0, base / 2));
            end
            6: win[k] = spr_pkg::PIXEL_BITS'($urandom_range(0, 3));
            7: win[k] = $urandom_range(0, 1) ? '1 : '0;
            8: win[k] = spr_pkg::PIXEL_BITS'(base);
            9: win[k] = spr_pkg::PIXEL_BITS'(65535 - $urandom_range(0, 15));
            default: win[k] = spr_pkg::PIXEL_BITS'($urandom_range(0, 65535));
         endcase
      end
      // A star-like window keeps its brightest pixel in the middle.
      if (shape == 4 || shape == 5)
         win[4] = spr_pkg::PIXEL_BITS'(base);
      // A flat window gets one pixel disturbed to break a single tie.
      if (shape == 8)
         win[$urandom_range(0, 8)] = spr_pkg::PIXEL_BITS'($urandom_range(0, 65535));
      return win;
   endfunction

   function automatic logic [spr_pkg::COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return spr_pkg::COORD_W'($urandom_range(0, 16383));
      endcase
   endfunction

   // Register settings for the random phases: the maximum, zero, the top of the
   // field, just past the maximum, small counts, one below the maximum, one random.
   int unsigned iteration_plan [8] = '{16, 0, 31, 17, 1, 2, 15, 7};

   initial begin : stimulus
      int phase, n;
      req.valid        = 1'b0;
      req.p_up_left    = '0;
      req.p_up         = '0;
      req.p_up_right   = '0;
      req.p_left       = '0;
      req.p_center     = '0;
      req.p_right      = '0;
      req.p_down_left  = '0;
      req.p_down       = '0;
      req.p_down_right = '0;
      req.start_x      = '0;
      req.start_y      = '0;
      rsp.ready        = 1'b0;
      iteration_plan[7] = $urandom_range(0, 31);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed windows run with the iteration count left at its reset
      // value: extremes of pixels and positions, each quadrant winning on
      // its own, and the ties that the fixed preference order decides.
      send_window('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, 0);
      send_window('{65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535},
                  16383, 16383);
      send_window('{0, 0, 0, 0, 65535, 0, 0, 0, 0}, 100, 200);
      send_window('{65535, 60000, 0, 60000, 50000, 0, 0, 0, 0}, 16383, 0);
      send_window('{0, 60000, 65535, 0, 50000, 60000, 0, 0, 0}, 0, 16383);
      send_window('{0, 0, 0, 0, 50000, 60000, 0, 60000, 65535}, 8191, 8192);
      send_window('{0, 0, 0, 60000, 50000, 0, 65535, 60000, 0}, 1, 1);
      // A bright right neighbor ties up-right with down-right.
      send_window('{0, 0, 0, 0, 1000, 65535, 0, 0, 0}, 5000, 5000);
      // A bright lower neighbor ties down-right with down-left.
      send_window('{0, 0, 0, 0, 1000, 0, 0, 65535, 0}, 5000, 5000);
      // A bright left neighbor ties up-left with down-left.
      send_window('{0, 0, 0, 65535, 1000, 0, 0, 0, 0}, 5000, 5000);
      // A bright upper neighbor ties up-left with up-right.
      send_window('{0, 65535, 0, 0, 1000, 0, 0, 0, 0}, 5000, 5000);
      send_window('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 14'h2AAA, 14'h1555);
      send_window('{65535, 0, 65535, 0, 0, 0, 65535, 0, 65535}, 16383, 16383);
      send_window('{0, 8191, 16382, 24573, 32764, 40955, 49146, 57337, 65528},
                  16383, 0);
      send_window('{0, 0, 0, 0, 0, 0, 0, 0, 65535}, 0, 16383);
      send_window('{1, 1, 1, 1, 1, 1, 1, 1, 1}, 12345, 54);
      send_window('{65535, 65535, 65535, 65535, 0, 65535, 65535, 65535, 65535},
                  777, 9999);

      // Random phases, one per register setting. The fourth phase runs with
      // no idle cycles on either side to keep every pipeline stage busy.
      for (phase = 0; phase < 8; phase++) begin
         set_iterations(spr_pkg::ITER_W'(iteration_plan[phase]));
         steady = (phase == 3);
         for (n = 0; n < 200; n++)
            send_window(random_window(), random_coord(), random_coord());
         steady = 1'b0;
      end

      // Drain, then give a late or extra result time to show up.
      req.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // This timeout allows far more time than the whole run needs.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
